### hdl/interval_dp_end_pick_max_profit_defines.svh
// ----------------------------------------------------------------------------
// interval_dp_end_pick_max_profit_defines
// Assertion macros for the checker file of the interval DP block.
// Each macro expands to one labeled concurrent assertion on clk, disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_DP_END_PICK_MAX_PROFIT_DEFINES_SVH
`define INTERVAL_DP_END_PICK_MAX_PROFIT_DEFINES_SVH

// Same-cycle implication.
`define IDPMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IDPMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/idpmp_pkg.sv
// ----------------------------------------------------------------------------
// idpmp_pkg
// Types, widths and helpers shared by the end-picking interval DP block.
// ----------------------------------------------------------------------------
`default_nettype none

package idpmp_pkg;

	// Row capacity and field widths.
	localparam int MAX_ITEMS = 64;
	localparam int PRICE_W   = 16;
	localparam int PROFIT_W  = 28;
	localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int YEAR_W    = COUNT_W;
	localparam int PROD_W    = PRICE_W + YEAR_W;
	localparam int SUM_W     = ((PROD_W > PROFIT_W) ? PROD_W : PROFIT_W) + 1;

	localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

	// Controller states, one-hot.
	typedef enum logic [3:0] {
		S_LOAD = 4'b0001,
		S_MUL  = 4'b0010,
		S_ADD  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	// Controls broadcast from the sequencer to every cell.
	typedef struct packed {
		logic              mul;
		logic              add;
		logic              first;
		logic [YEAR_W-1:0] year;
	} cell_ctl_t;

	// Clamp a widened sum to the profit range.
	function automatic logic [PROFIT_W-1:0] sat_profit(input logic [SUM_W-1:0] v);
		logic [PROFIT_W-1:0] res;
		if (v > SUM_W'(PROFIT_MAX)) begin
			res = PROFIT_MAX;
		end else begin
			res = v[PROFIT_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### hdl/idpmp_cell.sv
// ----------------------------------------------------------------------------
// idpmp_cell
// One position of the DP chain: holds a stored price, a shifting copy of the
// price at the right end of its interval, and the best profit of its interval.
// ----------------------------------------------------------------------------
`default_nettype none

module idpmp_cell (
	input  wire logic                             clk,
	input  wire logic                             load_hit,
	input  wire logic [idpmp_pkg::PRICE_W-1:0]    price_in,
	input  wire idpmp_pkg::cell_ctl_t             ctl,
	input  wire logic [idpmp_pkg::PRICE_W-1:0]    nb_right,
	input  wire logic [idpmp_pkg::PROFIT_W-1:0]   nb_best,
	output logic      [idpmp_pkg::PRICE_W-1:0]    right_out,
	output logic      [idpmp_pkg::PROFIT_W-1:0]   best_out
);

	logic [idpmp_pkg::PRICE_W-1:0]  left_q;
	logic [idpmp_pkg::PRICE_W-1:0]  right_q;
	logic [idpmp_pkg::PROFIT_W-1:0] best_q;
	logic [idpmp_pkg::PROD_W-1:0]   prod_l_s1;
	logic [idpmp_pkg::PROD_W-1:0]   prod_r_s1;
	logic [idpmp_pkg::SUM_W-1:0]    take_l;
	logic [idpmp_pkg::SUM_W-1:0]    take_r;
	logic [idpmp_pkg::SUM_W-1:0]    pick;

	// Price registers: loaded from the input, the right-end copy shifts one
	// place toward the head of the chain after every interval length.
	always_ff @(posedge clk) begin
		if (load_hit) begin
			left_q  <= price_in;
			right_q <= price_in;
		end else if (ctl.add) begin
			right_q <= nb_right;
		end
	end

	// Stage one: price times selling year for both ends.
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_l_s1 <= idpmp_pkg::PROD_W'(left_q)  * idpmp_pkg::PROD_W'(ctl.year);
			prod_r_s1 <= idpmp_pkg::PROD_W'(right_q) * idpmp_pkg::PROD_W'(ctl.year);
		end
	end

	// Stage two: add the remaining interval's best and keep the larger choice.
	always_comb begin
		take_l = idpmp_pkg::SUM_W'(prod_l_s1) + idpmp_pkg::SUM_W'(nb_best);
		take_r = idpmp_pkg::SUM_W'(prod_r_s1) + idpmp_pkg::SUM_W'(best_q);
		if (ctl.first) begin
			pick = idpmp_pkg::SUM_W'(prod_l_s1);
		end else if (take_l > take_r) begin
			pick = take_l;
		end else begin
			pick = take_r;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add) begin
			best_q <= idpmp_pkg::sat_profit(pick);
		end
	end

	assign right_out = right_q;
	assign best_out  = best_q;

endmodule

`default_nettype wire

### hdl/idpmp_ctrl.sv
// ----------------------------------------------------------------------------
// idpmp_ctrl
// Sequencer: counts loaded items, tracks overflow, and steps the cell chain
// through one interval length at a time (a multiply state, then an add state) down to the first year.
// ----------------------------------------------------------------------------
`default_nettype none

module idpmp_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              last,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   overflow,
	output logic                                   load_en,
	output logic      [idpmp_pkg::COUNT_W-1:0]     load_idx,
	output idpmp_pkg::cell_ctl_t                   ctl
);

	idpmp_pkg::state_t state_q;
	logic [idpmp_pkg::COUNT_W-1:0] count_q;
	logic [idpmp_pkg::YEAR_W-1:0]  year_q;
	logic                          first_q;
	logic                          ovf_q;
	logic                          accept;
	logic                          room;

	assign in_stall  = (state_q != idpmp_pkg::S_LOAD);
	assign accept    = in_valid && !in_stall;
	assign room      = (count_q < idpmp_pkg::COUNT_W'(idpmp_pkg::MAX_ITEMS));
	assign load_en   = accept && room;
	assign load_idx  = count_q;
	assign out_valid = (state_q == idpmp_pkg::S_OUT);
	assign overflow  = ovf_q;

	assign ctl.mul   = (state_q == idpmp_pkg::S_MUL);
	assign ctl.add   = (state_q == idpmp_pkg::S_ADD);
	assign ctl.first = first_q;
	assign ctl.year  = year_q;

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idpmp_pkg::S_LOAD;
			count_q <= '0;
			year_q  <= '0;
			first_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				idpmp_pkg::S_LOAD: begin
					if (accept) begin
						if (room) begin
							count_q <= idpmp_pkg::COUNT_W'(count_q + 1'b1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							year_q  <= room ? idpmp_pkg::YEAR_W'(count_q + 1'b1) : count_q;
							first_q <= 1'b1;
							state_q <= idpmp_pkg::S_MUL;
						end
					end
				end
				idpmp_pkg::S_MUL: begin
					state_q <= idpmp_pkg::S_ADD;
				end
				idpmp_pkg::S_ADD: begin
					first_q <= 1'b0;
					if (year_q == idpmp_pkg::YEAR_W'(1)) begin
						state_q <= idpmp_pkg::S_OUT;
					end else begin
						year_q  <= idpmp_pkg::YEAR_W'(year_q - 1'b1);
						state_q <= idpmp_pkg::S_MUL;
					end
				end
				idpmp_pkg::S_OUT: begin
					if (!out_stall) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= idpmp_pkg::S_LOAD;
					end
				end
				default: begin
					state_q <= idpmp_pkg::S_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/interval_dp_end_pick_max_profit.sv
// ----------------------------------------------------------------------------
// interval_dp_end_pick_max_profit
// Usage: maximum profit of selling a row of items from either end.
// The input channel (in_valid, in_stall, price, last) takes one price per
// request; last marks the final price of a row. Up to MAX_ITEMS prices are
// stored; further ones are dropped and flagged through overflow.
// Loading takes a price on every request while in_stall is low. After the
// request carrying last, the chain of cells solves one interval length at a
// time (a multiply stage, then an add-and-compare stage), from the shortest
// up to the whole row, and then shows its result.
// The output channel (out_valid, out_stall, profit, overflow) then holds one
// result until it is taken. While a row is being solved or its result waits,
// in_stall is high, so the next row cannot load until the result is taken.
// Reset clears the item count, the overflow flag and the sequencer; the
// price and profit registers of the cells hold no reset value; cells past the
// stored row can be read before this row writes them, but never feed the result.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_dp_end_pick_max_profit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [idpmp_pkg::PRICE_W-1:0]   price,
	input  wire logic                            last,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [idpmp_pkg::PROFIT_W-1:0]  profit,
	output logic                                 overflow
);

	logic                                load_en;
	logic [idpmp_pkg::COUNT_W-1:0]       load_idx;
	idpmp_pkg::cell_ctl_t                ctl;
	logic [idpmp_pkg::PRICE_W-1:0]       right_w [idpmp_pkg::MAX_ITEMS];
	logic [idpmp_pkg::PROFIT_W-1:0]      best_w  [idpmp_pkg::MAX_ITEMS];

	idpmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.overflow  (overflow),
		.load_en   (load_en),
		.load_idx  (load_idx),
		.ctl       (ctl)
	);

	// Chain of cells; each takes its neighbor's right-end price and best.
	for (genvar i = 0; i < idpmp_pkg::MAX_ITEMS; i++) begin : g_cell
		logic                               hit;
		logic [idpmp_pkg::PRICE_W-1:0]      nb_right;
		logic [idpmp_pkg::PROFIT_W-1:0]     nb_best;

		assign hit = load_en && (load_idx == idpmp_pkg::COUNT_W'(i));

		if (i == idpmp_pkg::MAX_ITEMS - 1) begin : g_tail
			assign nb_right = '0;
			assign nb_best  = '0;
		end else begin : g_body
			assign nb_right = right_w[i+1];
			assign nb_best  = best_w[i+1];
		end

		idpmp_cell u_cell (
			.clk       (clk),
			.load_hit  (hit),
			.price_in  (price),
			.ctl       (ctl),
			.nb_right  (nb_right),
			.nb_best   (nb_best),
			.right_out (right_w[i]),
			.best_out  (best_w[i])
		);
	end

	// The head cell holds the whole row's answer once the last length is done.
	assign profit = best_w[0];

endmodule

`default_nettype wire

### hdl/idpmp_chk.sv
// ----------------------------------------------------------------------------
// idpmp_chk
// Port-level checks of the interval DP block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interval_dp_end_pick_max_profit_defines.svh"

module idpmp_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire logic [idpmp_pkg::PRICE_W-1:0]   price,
	input wire logic                            last,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic [idpmp_pkg::PROFIT_W-1:0]  profit,
	input wire logic                            overflow
);

	// A stalled result keeps its value.
	`IDPMP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(profit) && $stable(overflow), "stalled result changed")

	// No request is taken while a result waits.
	`IDPMP_ASSERT_NOW(a_busy_out, out_valid, in_stall, "input open while result pending")

	// The request ending a row closes the input for solving.
	`IDPMP_ASSERT_NEXT(a_row_end, in_valid && !in_stall && last, in_stall && !out_valid, "row end did not start solving")

	// Without a row end the input stays open and no result appears.
	`IDPMP_ASSERT_NEXT(a_no_spurious, in_valid && !in_stall && !last, !out_valid && !in_stall, "result without row end")

endmodule

bind interval_dp_end_pick_max_profit idpmp_chk u_idpmp_chk (.*);

`default_nettype wire

### sim/interval_dp_end_pick_max_profit_tb.sv
// ----------------------------------------------------------------------------
// interval_dp_end_pick_max_profit_tb
// Self-checking bench for the end-picking maximum profit block.
// Rows of prices go in as requests, with last on the final one of each row.
// A local predictor stores each row and solves the interval DP. Every profit
// and overflow flag that comes out is compared with the oldest prediction.
// The rows are short in most cases, with a few full rows and a few
// overflowing ones. Both channels idle at random, apart from one quiet stretch.
// ----------------------------------------------------------------------------
module interval_dp_end_pick_max_profit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ITEMS = idpmp_pkg::MAX_ITEMS;
	localparam int PRICE_W   = idpmp_pkg::PRICE_W;
	localparam int PROFIT_W  = idpmp_pkg::PROFIT_W;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ROW_ITEMS = 1050;
	localparam int DRAIN_WAIT = 2 * MAX_ITEMS + 20;

	// One price request, optionally held back until every earlier row's result has been taken.
	typedef struct {
		logic [PRICE_W-1:0] p;
		logic               lst;
		bit                 drain;
	} price_req_t;

	typedef struct {
		logic [PROFIT_W-1:0] profit;
		logic                overflow;
	} row_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [PRICE_W-1:0]  price = '0;
	logic                last = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [PROFIT_W-1:0] profit;
	logic                overflow;

	price_req_t  req_queue[$];
	row_result_t profit_due[$];
	price_req_t  next_req;

	// Predictor state: the row being loaded.
	logic [PRICE_W-1:0] row_price[MAX_ITEMS];
	int                 row_len = 0;
	bit                 row_over = 1'b0;

	bit in_took = 1'b0;
	int taken_cnt = 0;
	int err_count = 0;
	int cycle_cnt = 0;
	int queued_items = 0;

	// The random idling is switched off while this window of requests goes in.
	wire calm = (taken_cnt >= 300) && (taken_cnt < 450);

	interval_dp_end_pick_max_profit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.price    (price),
		.last     (last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.profit   (profit),
		.overflow (overflow)
	);

	always #4 clk = ~clk;

	// Report one mismatch and count it.
	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_cnt);
		err_count++;
	endtask

	function automatic bit [63:0] clamp_profit(input bit [63:0] v);
		return (v > 64'(idpmp_pkg::PROFIT_MAX)) ? 64'(idpmp_pkg::PROFIT_MAX) : v;
	endfunction

	// Best total over all orders of selling the stored row from either end.
	// Entry i holds the best profit for the interval starting at i.
	function automatic logic [PROFIT_W-1:0] end_pick_best(input int n);
		bit [63:0] dp_row[MAX_ITEMS];
		bit [63:0] year;
		bit [63:0] take_left;
		bit [63:0] take_right;
		for (int i = 0; i < n; i++) begin
			dp_row[i] = clamp_profit(64'(row_price[i]) * 64'(n));
		end
		for (int len = 2; len <= n; len++) begin
			year = 64'(n - len + 1);
			for (int i = 0; i + len <= n; i++) begin
				take_left = 64'(row_price[i]) * year + dp_row[i + 1];
				take_right = 64'(row_price[i + len - 1]) * year + dp_row[i];
				dp_row[i] = clamp_profit((take_left > take_right) ? take_left : take_right);
			end
		end
		return dp_row[0][PROFIT_W-1:0];
	endfunction

	// Store an accepted price; on the last one predict the row's result.
	task automatic load_price(input logic [PRICE_W-1:0] p, input logic lst);
		row_result_t res;
		if (row_len < MAX_ITEMS) begin
			row_price[row_len] = p;
			row_len++;
		end else begin
			row_over = 1'b1;
		end
		if (lst) begin
			res.profit = end_pick_best(row_len);
			res.overflow = row_over;
			profit_due.push_back(res);
			row_len = 0;
			row_over = 1'b0;
		end
	endtask

	// Queue one row of n prices. Kind 0: any value, 1: small values,
	// 2: extremes mixed with random values, 3: every price at its maximum.
	task automatic add_row(input int n, input int kind, input bit drain);
		price_req_t r;
		for (int i = 0; i < n; i++) begin
			case (kind)
				0: begin
					r.p = PRICE_W'($urandom);
				end
				1: begin
					r.p = PRICE_W'($urandom_range(15));
				end
				2: begin
					case ($urandom_range(2))
						0: r.p = '0;
						1: r.p = '1;
						default: r.p = PRICE_W'($urandom);
					endcase
				end
				default: begin
					r.p = '1;
				end
			endcase
			r.lst = (i == n - 1);
			r.drain = drain && (i == 0);
			req_queue.push_back(r);
		end
		queued_items += n;
	endtask

	task automatic add_fixed(input logic [PRICE_W-1:0] p, input logic lst);
		price_req_t r;
		r.p = p;
		r.lst = lst;
		r.drain = 1'b0;
		req_queue.push_back(r);
		queued_items++;
	endtask

	// Request driver: a new price goes out only once the previous one was taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// Hold the stalled request as it is.
		end else if (req_queue.size() > 0 && req_queue[0].drain && profit_due.size() > 0) begin
			in_valid <= 1'b0;
		end else if (req_queue.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
			next_req = req_queue.pop_front();
			in_valid <= 1'b1;
			price <= next_req.p;
			last <= next_req.lst;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		if (!arst_n || calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 31);
		end
	end

	// Monitor: predict on every accepted request, check every accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				load_price(price, last);
				taken_cnt++;
			end
			if (out_valid && !out_stall) begin
				if (profit_due.size() == 0) begin
					flag_mismatch("unexpected result, profit", profit, 0);
				end else begin
					if (profit !== profit_due[0].profit) begin
						flag_mismatch("profit", profit, profit_due[0].profit);
					end
					if (overflow !== profit_due[0].overflow) begin
						flag_mismatch("overflow", overflow, profit_due[0].overflow);
					end
					void'(profit_due.pop_front());
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int n;
		int pick;
		bit drained;
		drained = 1'b0;

		// Directed rows: single items at both extremes, short rows with
		// extreme prices, two textbook rows and a row of maximum prices.
		add_fixed('0, 1'b1);
		add_fixed('1, 1'b1);
		add_fixed(16'd1, 1'b0);
		add_fixed('1, 1'b1);
		add_fixed('1, 1'b0);
		add_fixed('0, 1'b1);
		add_fixed(16'd2, 1'b0);
		add_fixed(16'd3, 1'b0);
		add_fixed(16'd5, 1'b1);
		add_fixed(16'd2, 1'b0);
		add_fixed(16'd4, 1'b0);
		add_fixed(16'd6, 1'b0);
		add_fixed(16'd2, 1'b0);
		add_fixed(16'd5, 1'b1);
		add_fixed(16'h5555, 1'b0);
		add_fixed(16'hAAAA, 1'b1);
		add_row(4, 3, 1'b0);

		// Random rows: mostly short, some long, full and overflowing.
		// A full row of maximum prices gives the largest possible profit.
		add_row(MAX_ITEMS, 3, 1'b0);
		add_row(MAX_ITEMS + 1, 0, 1'b0);
		while (queued_items < ROW_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				n = $urandom_range(1, 12);
			end else if (pick < 88) begin
				n = $urandom_range(13, 40);
			end else begin
				n = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
			end
			if (!drained && queued_items >= ROW_ITEMS / 2) begin
				add_row(n, $urandom_range(2), 1'b1);
				drained = 1'b1;
			end else begin
				add_row(n, (pick >= 97) ? 3 : $urandom_range(2), $urandom_range(49) == 0);
			end
		end

		// Reset once, then let the request driver run.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_queue.size() > 0 || in_valid) @(negedge clk);
		while (profit_due.size() > 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (profit_due.size() != 0) begin
			flag_mismatch("results still outstanding", 0, profit_due.size());
		end
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
